[sv/ibrm_pkg.sv]
// Package for the bound-pointer register machine step.
// Holds opcodes, configuration indexes, machine sizes and the beat structs.
// No dependencies.
package ibrm_pkg;

	localparam int NUM_REGS      = 6;
	localparam int PROGRAM_DEPTH = 64;
	localparam int WORD_W        = 64;
	localparam int LEN_W         = 7;
	localparam int CFG_IDX_W     = 2;

	typedef enum logic [4:0] {
		OP_ADDI = 5'd0,
		OP_ADDR = 5'd1,
		OP_BANI = 5'd2,
		OP_BANR = 5'd3,
		OP_BORI = 5'd4,
		OP_BORR = 5'd5,
		OP_EQIR = 5'd6,
		OP_EQRI = 5'd7,
		OP_EQRR = 5'd8,
		OP_GTIR = 5'd9,
		OP_GTRI = 5'd10,
		OP_GTRR = 5'd11,
		OP_MULI = 5'd12,
		OP_MULR = 5'd13,
		OP_SETI = 5'd14,
		OP_SETR = 5'd15
	} ibrm_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOUND_REG   = 2'd0,
		CFG_PROG_LEN    = 2'd1,
		CFG_FIRST_START = 2'd2
	} ibrm_cfg_idx_t;

	typedef struct packed {
		logic [4:0]         opcode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
		logic [2:0]         dest_index;
	} ibrm_instr_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] next_pointer;
		logic                     halted;
		logic signed [WORD_W-1:0] written_value;
		logic signed [WORD_W-1:0] register_zero;
		logic                     bad_instruction;
	} ibrm_result_t;

endpackage

[sv/ibrm_alu.sv]
// Operation unit of the register machine: add, and, or, compare, wrapping multiply, pass-through.
// Depends on ibrm_pkg.
module ibrm_alu import ibrm_pkg::*; (
	input  logic [4:0]        opcode,
	input  logic [WORD_W-1:0] ra,
	input  logic [WORD_W-1:0] rb,
	output logic [WORD_W-1:0] r
);

	logic [63:0] pp_ll;
	logic [63:0] pp_lh;
	logic [63:0] pp_hl;
	logic [31:0] mid_sum;
	logic [63:0] prod;

	// low 64 bits of the product from three 32x32 partial products
	always_comb begin
		pp_ll   = 64'(ra[31:0]) * 64'(rb[31:0]);
		pp_lh   = 64'(ra[31:0]) * 64'(rb[63:32]);
		pp_hl   = 64'(ra[63:32]) * 64'(rb[31:0]);
		mid_sum = pp_lh[31:0] + pp_hl[31:0];
		prod    = pp_ll + {mid_sum, 32'd0};
	end

	always_comb begin
		unique case (ibrm_op_t'(opcode))
			OP_ADDI, OP_ADDR:          r = ra + rb;
			OP_BANI, OP_BANR:          r = ra & rb;
			OP_BORI, OP_BORR:          r = ra | rb;
			OP_EQIR, OP_EQRI, OP_EQRR: r = 64'(ra == rb);
			OP_GTIR, OP_GTRI, OP_GTRR: r = 64'($signed(ra) > $signed(rb));
			OP_MULI, OP_MULR:          r = prod;
			default:                   r = ra;
		endcase
	end

endmodule

[sv/ibrm_core.sv]
// Machine state and one-pass execution: register file, pointer, stop flag, config.
// Depends on ibrm_pkg and ibrm_alu.
module ibrm_core import ibrm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_wdata,
	input  logic                 exec,
	input  ibrm_instr_t          instr,
	output ibrm_result_t         res
);

	logic [WORD_W-1:0] rf_q [NUM_REGS];
	logic [WORD_W-1:0] ip_q;
	logic              stopped_q;
	logic [2:0]        bound_reg_q;
	logic [LEN_W-1:0]  prog_len_q;

	logic [WORD_W-1:0] rf_m [NUM_REGS];
	logic [WORD_W-1:0] rf_n [NUM_REGS];
	logic [LEN_W-1:0]  len;
	logic              run;
	logic              bound_ok;
	logic              a_reg, b_reg, known;
	logic              a_ok, b_ok, dst_ok;
	logic              bad;
	logic [WORD_W-1:0] ra, rb, r;
	logic [WORD_W-1:0] base;
	logic [WORD_W-1:0] next_ptr;
	logic [WORD_W-1:0] written;
	logic              halt;

	ibrm_alu u_alu (
		.opcode (instr.opcode),
		.ra     (ra),
		.rb     (rb),
		.r      (r)
	);

	always_comb begin
		len      = (prog_len_q > LEN_W'(PROGRAM_DEPTH)) ? LEN_W'(PROGRAM_DEPTH) : prog_len_q;
		run      = !stopped_q && (ip_q < WORD_W'(len));
		bound_ok = bound_reg_q < 3'(NUM_REGS);

		// mirror the pointer into the bound register first
		for (int i = 0; i < NUM_REGS; i++) begin
			rf_m[i] = (bound_ok && bound_reg_q == 3'(i)) ? ip_q : rf_q[i];
		end

		a_reg = 1'b0;
		b_reg = 1'b0;
		known = 1'b1;
		unique case (ibrm_op_t'(instr.opcode))
			OP_ADDI, OP_BANI, OP_BORI, OP_GTRI, OP_MULI, OP_SETR, OP_EQRI: a_reg = 1'b1;
			OP_ADDR, OP_BANR, OP_BORR, OP_EQRR, OP_GTRR, OP_MULR: begin
				a_reg = 1'b1;
				b_reg = 1'b1;
			end
			OP_EQIR, OP_GTIR: b_reg = 1'b1;
			OP_SETI: ;
			default: known = 1'b0;
		endcase

		a_ok   = $unsigned(instr.operand_a) < 32'(NUM_REGS);
		b_ok   = $unsigned(instr.operand_b) < 32'(NUM_REGS);
		dst_ok = instr.dest_index < 3'(NUM_REGS);
		bad    = !known || !dst_ok || (a_reg && !a_ok) || (b_reg && !b_ok);

		ra = {{32{instr.operand_a[31]}}, instr.operand_a};
		rb = {{32{instr.operand_b[31]}}, instr.operand_b};
		for (int i = 0; i < NUM_REGS; i++) begin
			if (a_reg && instr.operand_a[2:0] == 3'(i))
				ra = rf_m[i];
			if (b_reg && instr.operand_b[2:0] == 3'(i))
				rb = rf_m[i];
		end

		for (int i = 0; i < NUM_REGS; i++) begin
			rf_n[i] = (!bad && instr.dest_index == 3'(i)) ? r : rf_m[i];
		end

		base    = ip_q;
		written = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (bound_ok && bound_reg_q == 3'(i))
				base = rf_n[i];
			if (instr.dest_index == 3'(i))
				written = rf_n[i];
		end
		next_ptr = base + WORD_W'(1);
		halt     = !(next_ptr < WORD_W'(len));

		if (run) begin
			res.next_pointer    = next_ptr;
			res.halted          = halt;
			res.written_value   = written;
			res.register_zero   = rf_n[0];
			res.bad_instruction = bad;
		end else begin
			res.next_pointer    = ip_q;
			res.halted          = 1'b1;
			res.written_value   = '0;
			res.register_zero   = rf_q[0];
			res.bad_instruction = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
			ip_q        <= '0;
			stopped_q   <= 1'b0;
			bound_reg_q <= '0;
			prog_len_q  <= '0;
		end else begin
			if (exec) begin
				if (run) begin
					for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= rf_n[i];
					ip_q      <= next_ptr;
					stopped_q <= halt;
				end else begin
					stopped_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				unique case (ibrm_cfg_idx_t'(cfg_index))
					CFG_BOUND_REG:   bound_reg_q <= cfg_wdata[2:0];
					CFG_PROG_LEN:    prog_len_q  <= cfg_wdata[LEN_W-1:0];
					CFG_FIRST_START: rf_q[0]     <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

[sv/ip_bound_register_machine_step.sv]
// Top level of the bound-pointer register machine step: input stage, core, result stage.
// Depends on ibrm_pkg and ibrm_core.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------------
//  in      | in_valid / in_stall        | opcode, operand_a, operand_b, dest_index
//  out     | out_valid / out_stall      | next_pointer, halted, written_value,
//          |                            | register_zero, bad_instruction
//  cfg     | cfg_we, cfg_index          | cfg_wdata (0 bound reg, 1 length, 2 reg zero)
//
// One beat in, one beat out, one beat per cycle sustained while out is not stalled; an
// instruction is taken into the input register, executed into the result register and
// offered from there. The rate is set by the execute loop, in one pass: register file
// read, ALU with three 32x32 partial products, register file and pointer write-back.
// Reset clears the register file, pointer, stop flag, configuration and valid flags.
// A stall on out holds the result register; the input register then holds too, and
// in_stall rises only once both are full.
module ip_bound_register_machine_step import ibrm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [WORD_W-1:0]        cfg_wdata,
	// instruction channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [4:0]               opcode,
	input  logic signed [31:0]       operand_a,
	input  logic signed [31:0]       operand_b,
	input  logic [2:0]               dest_index,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] next_pointer,
	output logic                     halted,
	output logic signed [WORD_W-1:0] written_value,
	output logic signed [WORD_W-1:0] register_zero,
	output logic                     bad_instruction
);

	ibrm_instr_t  instr_s1;
	logic         valid_s1;
	ibrm_result_t core_res;
	ibrm_result_t res_q;
	logic         out_valid_q;
	logic         exec;
	logic         accept;

	// execute the held instruction whenever the result register is free or draining
	assign exec     = valid_s1 && (!out_valid_q || !out_stall);
	// stall only while the input register is full and cannot move on
	assign in_stall = valid_s1 && !exec;
	assign accept   = in_valid && !in_stall;

	ibrm_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.exec      (exec),
		.instr     (instr_s1),
		.res       (core_res)
	);

	// input register: capture each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1.opcode     <= opcode;
			instr_s1.operand_a  <= operand_a;
			instr_s1.operand_b  <= operand_b;
			instr_s1.dest_index <= dest_index;
		end
	end

	// result register: load on execute, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			res_q <= core_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign next_pointer    = res_q.next_pointer;
	assign halted          = res_q.halted;
	assign written_value   = res_q.written_value;
	assign register_zero   = res_q.register_zero;
	assign bad_instruction = res_q.bad_instruction;

endmodule

[sv/ibrm_checker.sv]
// Port-level checks for the bound-pointer register machine step, bound to the top level.
// Depends on ibrm_pkg and ip_bound_register_machine_step.
module ibrm_checker import ibrm_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [WORD_W-1:0] next_pointer,
	input logic                     halted
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped under stall");

	// a stalled result keeps its pointer
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(next_pointer))
		else $error("stalled result pointer changed");

	// with the result register empty there is room to take an instruction
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while result register empty");

	// a running pointer always lies inside the program store
	a_ptr_in_prog: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !halted |-> (next_pointer[WORD_W-1:6] == '0))
		else $error("running pointer outside the program");

endmodule

bind ip_bound_register_machine_step ibrm_checker u_ibrm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.next_pointer (next_pointer),
	.halted       (halted)
);
